// ===== rtl/core/lfu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants for the LFU cache replacement core.
// ----------------------------------------------------------------------------
package lfu_pkg;

	localparam int IN_TDATA_W  = 32;
	localparam int SLOT_W      = 4;
	localparam int TOTAL_W     = 32;
	localparam int OUT_FIELD_W = 1 + SLOT_W + 1 + TOTAL_W + TOTAL_W;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_SCAN,
		ST_APPLY
	} lfu_state_t;

	typedef struct packed {
		logic load;
		logic bump;
	} cell_cmd_t;

endpackage

// ===== rtl/core/lfu_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cell
// One directory slot: key, use count, key compare and one step of the
// least-used chain that runs from slot 0 to the last slot.
// ----------------------------------------------------------------------------
module lfu_cell #(
	parameter int KEY_WIDTH   = 32,
	parameter int COUNT_WIDTH = 32,
	parameter int IDX_W       = 4,
	parameter int INDEX       = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lfu_pkg::cell_cmd_t     cmd,
	input  logic [KEY_WIDTH-1:0]   key,
	input  logic                   filled,
	output logic                   match,
	input  logic                   min_in_valid,
	input  logic [COUNT_WIDTH-1:0] min_in_cnt,
	input  logic [IDX_W-1:0]       min_in_idx,
	output logic [COUNT_WIDTH-1:0] min_cnt,
	output logic [IDX_W-1:0]       min_idx
);
	import lfu_pkg::*;

	logic [KEY_WIDTH-1:0]   key_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [COUNT_WIDTH-1:0] min_cnt_q;
	logic [IDX_W-1:0]       min_idx_q;
	logic                   take_own;

	assign match    = filled && (key_q == key);
	assign take_own = !min_in_valid || (count_q < min_in_cnt);
	assign min_cnt  = min_cnt_q;
	assign min_idx  = min_idx_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.load) begin
			count_q <= COUNT_WIDTH'(1);
		end else if (cmd.bump && (count_q != '1)) begin
			count_q <= count_q + COUNT_WIDTH'(1);
		end
	end

	// strict less keeps the lower index on ties
	always_ff @(posedge clk) begin
		if (take_own) begin
			min_cnt_q <= count_q;
			min_idx_q <= IDX_W'(INDEX);
		end else begin
			min_cnt_q <= min_in_cnt;
			min_idx_q <= min_in_idx;
		end
	end

endmodule

// ===== rtl/core/lfu_cache_replacement_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cache_replacement_core
// Fully associative key directory with least-frequently-used replacement.
// ----------------------------------------------------------------------------
// the key word is registered in ST_IDLE and looked up in ST_MATCH; the result word is
//   registered in ST_APPLY; a new key word is taken only back in ST_IDLE; a miss on a
//   full directory with a stale minimum first waits in ST_SCAN for the min chain to settle
// the miss that fills the last empty slot keeps the core busy in ST_SCAN after its
//   result for the same chain pass
// reset: arst_n clears counts, fill level, totals and control; keys are not reset
module lfu_cache_replacement_core #(
	parameter int ENTRIES     = 16,
	parameter int KEY_WIDTH   = 32,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [lfu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // lookup_key
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// hit, slot, filled_empty, hit_total, miss_total, zero pad
	output logic [lfu_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import lfu_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int FW = $clog2(ENTRIES + 1);
	localparam int SW = (IW > SLOT_W) ? IW : SLOT_W;

	lfu_state_t state_q, state_d;

	logic [KEY_WIDTH-1:0]   key_q;
	logic [FW-1:0]          fill_q;
	logic [IW-1:0]          least_q;
	logic                   stale_q;
	logic [TOTAL_W-1:0]     hits_q;
	logic [TOTAL_W-1:0]     misses_q;
	logic                   hit_q;
	logic [IW-1:0]          hit_idx_q;
	logic [FW-1:0]          scan_cnt_q;
	logic                   post_q;
	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic [ENTRIES-1:0]     match;
	cell_cmd_t              cmd       [ENTRIES];
	logic [COUNT_WIDTH-1:0] chain_cnt [ENTRIES];
	logic [IW-1:0]          chain_idx [ENTRIES];

	logic                   full;
	logic                   will_fill;
	logic                   apply_go;
	logic                   scan_done;
	logic [IW-1:0]          hit_idx;
	logic [IW-1:0]          miss_idx;
	logic [IW-1:0]          res_idx;
	logic [SW-1:0]          res_ext;
	logic                   post_scan;

	genvar g;
	generate
		for (g = 0; g < ENTRIES; g++) begin : g_cell
			logic                   prev_valid;
			logic [COUNT_WIDTH-1:0] prev_cnt;
			logic [IW-1:0]          prev_idx;

			if (g == 0) begin : g_head
				assign prev_valid = 1'b0;
				assign prev_cnt   = '0;
				assign prev_idx   = '0;
			end else begin : g_link
				assign prev_valid = 1'b1;
				assign prev_cnt   = chain_cnt[g-1];
				assign prev_idx   = chain_idx[g-1];
			end

			assign cmd[g].load = apply_go && !hit_q && (miss_idx == IW'(g));
			assign cmd[g].bump = apply_go && hit_q && (hit_idx_q == IW'(g));

			lfu_cell #(
				.KEY_WIDTH  (KEY_WIDTH),
				.COUNT_WIDTH(COUNT_WIDTH),
				.IDX_W      (IW),
				.INDEX      (g)
			) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.cmd         (cmd[g]),
				.key         (key_q),
				.filled      (FW'(g) < fill_q),
				.match       (match[g]),
				.min_in_valid(prev_valid),
				.min_in_cnt  (prev_cnt),
				.min_in_idx  (prev_idx),
				.min_cnt     (chain_cnt[g]),
				.min_idx     (chain_idx[g])
			);
		end
	endgenerate

	always_comb begin
		hit_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_idx = IW'(i);
			end
		end
	end

	assign full      = (fill_q == FW'(ENTRIES));
	assign will_fill = full || (fill_q == FW'(ENTRIES - 1));
	assign miss_idx  = full ? least_q : fill_q[IW-1:0];
	assign res_idx   = hit_q ? hit_idx_q : miss_idx;
	assign res_ext   = SW'(res_idx);
	assign post_scan = !hit_q && will_fill && stale_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = ST_MATCH;
				end
			end
			ST_MATCH: begin
				if (!(|match) && full && stale_q) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_APPLY;
				end
			end
			ST_SCAN: begin
				if (scan_cnt_q == FW'(ENTRIES)) begin
					state_d = post_q ? ST_IDLE : ST_APPLY;
				end
			end
			ST_APPLY: begin
				if (!out_valid_q || m_axis_tready) begin
					state_d = post_scan ? ST_SCAN : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		apply_go      = (state_q == ST_APPLY) && (!out_valid_q || m_axis_tready);
		scan_done     = (state_q == ST_SCAN) && (scan_cnt_q == FW'(ENTRIES));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_cnt_q <= '0;
			post_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SCAN) begin
				scan_cnt_q <= scan_cnt_q + FW'(1);
			end else begin
				scan_cnt_q <= '0;
			end
			if (state_q == ST_MATCH) begin
				post_q <= 1'b0;
			end else if (apply_go) begin
				post_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			key_q <= KEY_WIDTH'(s_axis_tdata);
		end
		if (state_q == ST_MATCH) begin
			hit_q     <= |match;
			hit_idx_q <= hit_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			least_q  <= '0;
			stale_q  <= 1'b1;
			hits_q   <= '0;
			misses_q <= '0;
		end else if (scan_done) begin
			least_q <= chain_idx[ENTRIES-1];
			stale_q <= 1'b0;
		end else if (apply_go) begin
			if (hit_q) begin
				hits_q <= hits_q + TOTAL_W'(1);
				if (hit_idx_q == least_q) begin
					stale_q <= 1'b1;
				end
			end else begin
				misses_q <= misses_q + TOTAL_W'(1);
				if (!full) begin
					fill_q <= fill_q + FW'(1);
				end
				if (will_fill && !stale_q) begin
					least_q <= miss_idx;
					stale_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (apply_go) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply_go) begin
			out_data_q <= {
				{OUT_PAD_W{1'b0}},
				hit_q ? misses_q : misses_q + TOTAL_W'(1),
				hit_q ? hits_q + TOTAL_W'(1) : hits_q,
				!hit_q && !full,
				res_ext[SLOT_W-1:0],
				hit_q
			};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/core/lfu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_checker
// Port-level checks for the LFU cache replacement core, bound to the top.
// ----------------------------------------------------------------------------
module lfu_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic [lfu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [lfu_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import lfu_pkg::*;

	logic [1:0]         pend_q;
	logic [TOTAL_W-1:0] hits_q;
	logic [TOTAL_W-1:0] misses_q;
	logic               in_go;
	logic               out_go;
	logic               out_hit;
	logic               out_fresh;
	logic [TOTAL_W-1:0] out_hits;
	logic [TOTAL_W-1:0] out_misses;

	assign in_go      = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata);
	assign out_go     = m_axis_tvalid && m_axis_tready;
	assign out_hit    = m_axis_tdata[0];
	assign out_fresh  = m_axis_tdata[1 + SLOT_W];
	assign out_hits   = m_axis_tdata[2 + SLOT_W +: TOTAL_W];
	assign out_misses = m_axis_tdata[2 + SLOT_W + TOTAL_W +: TOTAL_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= '0;
			hits_q   <= '0;
			misses_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_go) - 2'(out_go);
			if (out_go) begin
				hits_q   <= out_hits;
				misses_q <= out_misses;
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pend_q != 2'd0)
		else $error("result word without a pending key");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two keys in flight");

	a_totals: assert property (@(posedge clk) disable iff (!arst_n)
		out_go |-> (out_hit && out_hits == hits_q + 32'd1 && out_misses == misses_q)
			|| (!out_hit && out_misses == misses_q + 32'd1 && out_hits == hits_q))
		else $error("hit or miss total out of step");

	a_hit_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_hit |-> !out_fresh)
		else $error("hit flagged as fresh fill");

endmodule

bind lfu_cache_replacement_core lfu_checker u_lfu_checker (.*);
